FILE: design/altv_pkg.sv
package altv_pkg;

    // text bytes the parser reacts to
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_M     = 8'h6d;
    localparam logic [7:0] CH_R     = 8'h72;

    // parse phases
    localparam logic [2:0] PH_MNEM    = 3'd0;
    localparam logic [2:0] PH_ARG1    = 3'd1;
    localparam logic [2:0] PH_ARG2    = 3'd2;
    localparam logic [2:0] PH_ARG3    = 3'd3;
    localparam logic [2:0] PH_COMMENT = 3'd4;

    // result status
    localparam logic [1:0] ST_STORED   = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_TOO_MANY = 2'd3;

    // line event kinds
    localparam logic [1:0] EVT_NONE     = 2'd0;
    localparam logic [1:0] EVT_FINISH   = 2'd1;
    localparam logic [1:0] EVT_TOO_LONG = 2'd2;
    localparam logic [1:0] EVT_TOO_MANY = 2'd3;

    // keyword codes
    localparam int         KW_COUNT    = 18;
    localparam logic [4:0] KW_LOAD     = 5'd0;
    localparam logic [4:0] KW_STORE    = 5'd1;
    localparam logic [4:0] KW_ADD      = 5'd2;
    localparam logic [4:0] KW_MOV      = 5'd9;
    localparam logic [4:0] KW_JNE      = 5'd12;
    localparam logic [4:0] KW_JMP      = 5'd13;
    localparam logic [4:0] KW_GETC     = 5'd16;
    localparam logic [4:0] KW_HALT     = 5'd17;
    localparam logic [4:0] KW_LABEL    = 5'd18;
    localparam logic [4:0] KW_ON_ERROR = 5'd0;

    localparam int QUEUE_DEPTH = 4;

    // keyword texts, first char in the low byte
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_0000_6461_6f6c,  // load
        64'h0000_0065_726f_7473,  // store
        64'h0000_0000_0064_6461,  // add
        64'h0000_0000_0062_7573,  // sub
        64'h0000_0000_006c_756d,  // mul
        64'h0000_0000_0076_6964,  // div
        64'h0000_0000_0064_6f6d,  // mod
        64'h0000_0000_7970_6f63,  // copy
        64'h0000_0000_0070_6d63,  // cmp
        64'h0000_0000_0076_6f6d,  // mov
        64'h0000_0000_0074_6573,  // set
        64'h0000_0000_0071_656a,  // jeq
        64'h0000_0000_0065_6e6a,  // jne
        64'h0000_0000_0070_6d6a,  // jmp
        64'h0000_0074_6e69_7270,  // print
        64'h0000_6374_6e69_7270,  // printc
        64'h0000_0000_6374_6567,  // getc
        64'h0000_0000_746c_6168   // halt
    };

    typedef struct packed {
        logic        prog_end;
        logic [1:0]  kind;
        logic [63:0] mnem;
        logic [63:0] arg0;
        logic [63:0] arg1;
        logic [63:0] arg2;
    } t_line_evt;

    typedef struct packed {
        logic       ok;
        logic [4:0] kw;
    } t_class;

    function automatic t_class f_classify(input logic [63:0] mnem,
                                          input logic [7:0]  a0,
                                          input logic [7:0]  a1);
        t_class              res;
        logic [KW_COUNT-1:0] hit;
        logic                r0;
        logic                r1;
        for (int k = 0; k < KW_COUNT; k++) begin
            hit[k] = (mnem == KW_TEXT[k]);
        end
        r0     = (a0 == CH_R) || (a0 == CH_A);
        r1     = (a1 == CH_R) || (a1 == CH_A);
        res.ok = 1'b0;
        res.kw = KW_ON_ERROR;
        if (a0 == CH_R && a1 == CH_M) begin
            res.ok = hit[KW_LOAD];
            res.kw = KW_LOAD;
        end else if (a0 == CH_M && r1) begin
            res.ok = hit[KW_STORE];
            res.kw = KW_STORE;
        end else if (r0 && r1) begin
            for (int k = KW_ADD; k <= KW_MOV; k++) begin
                if (hit[k]) begin
                    res.ok = 1'b1;
                    res.kw = 5'(k);
                end
            end
        end else if (r0 && a1 != CH_NUL) begin
            for (int k = KW_MOV; k <= KW_JNE; k++) begin
                if (hit[k]) begin
                    res.ok = 1'b1;
                    res.kw = 5'(k);
                end
            end
        end else if (a0 == CH_COLON) begin
            res.ok = 1'b1;
            res.kw = KW_LABEL;
        end else if (a0 != CH_NUL) begin
            for (int k = KW_JMP; k <= KW_GETC; k++) begin
                if (hit[k]) begin
                    res.ok = 1'b1;
                    res.kw = 5'(k);
                end
            end
        end else begin
            res.ok = hit[KW_HALT];
            res.kw = KW_HALT;
        end
        return res;
    endfunction

endpackage

FILE: design/altv_if.sv
interface altv_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface altv_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  keyword;
    logic [7:0]  slot;
    logic [63:0] mnemonic_text;
    logic [63:0] first_arg_text;
    logic [63:0] second_arg_text;
    logic [63:0] third_arg_text;

    modport source (output valid, output status, output keyword, output slot,
                    output mnemonic_text, output first_arg_text,
                    output second_arg_text, output third_arg_text, input ready);
    modport sink   (input valid, input status, input keyword, input slot,
                    input mnemonic_text, input first_arg_text,
                    input second_arg_text, input third_arg_text, output ready);
endinterface

FILE: design/altv_front.sv
module altv_front #(
    parameter int MNEMONIC_CHARS = 8,
    parameter int ARG_CHARS      = 8,
    parameter int ARG_COUNT      = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    altv_char_if.sink         i_char,
    input  logic              i_full,
    output logic              o_push,
    output altv_pkg::t_line_evt o_evt
);
    import altv_pkg::*;

    localparam int MNEM_W    = 8 * MNEMONIC_CHARS;
    localparam int ARG_W     = 8 * ARG_CHARS;
    localparam int MAX_CHARS = (MNEMONIC_CHARS > ARG_CHARS) ? MNEMONIC_CHARS : ARG_CHARS;
    localparam int POS_W     = $clog2(MAX_CHARS + 1);

    logic [2:0]                       r_phase,  n_phase;
    logic [POS_W-1:0]                 r_pos,    n_pos;
    logic [MNEM_W-1:0]                r_mnem,   n_mnem;
    logic [ARG_COUNT-1:0][ARG_W-1:0]  r_args,   n_args;
    logic                             r_halted, n_halted;

    logic        w_take;
    logic [7:0]  w_c;
    logic        w_eol;
    logic        w_blank;
    logic [1:0]  w_kind;
    logic        w_label;
    logic        w_clear;
    logic [63:0] w_lane [3];

    assign i_char.ready = !i_full;
    assign w_take  = i_char.valid && !i_full;
    assign w_c     = i_char.char_code;
    assign w_eol   = (w_c == CH_NUL) || (w_c == CH_LF) || (w_c == CH_CR);
    assign w_blank = (w_c == CH_SPACE) || (w_c == CH_TAB);

    for (genvar k = 0; k < 3; k++) begin : g_lane
        if (k < ARG_COUNT) begin : g_used
            assign w_lane[k] = 64'(r_args[k]);
        end else begin : g_unused
            assign w_lane[k] = 64'd0;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_mnem   = r_mnem;
        n_args   = r_args;
        n_halted = r_halted;
        w_kind   = EVT_NONE;
        w_label  = 1'b0;
        w_clear  = 1'b0;
        if (w_take && !r_halted) begin
            case (r_phase)
                PH_MNEM: begin
                    if (w_c == CH_SLASH) begin
                        n_mnem  = '0;
                        n_pos   = '0;
                        n_phase = PH_COMMENT;
                    end else if (w_blank) begin
                        if (r_pos != '0) begin
                            n_pos   = '0;
                            n_phase = PH_ARG1;
                        end
                    end else if (w_eol) begin
                        if (r_pos != '0) begin
                            w_kind  = EVT_FINISH;
                            w_clear = 1'b1;
                        end
                    end else if (w_c == CH_COLON) begin
                        w_kind  = EVT_FINISH;
                        w_label = 1'b1;
                        w_clear = 1'b1;
                    end else if (r_pos >= POS_W'(MNEMONIC_CHARS)) begin
                        w_kind   = EVT_TOO_LONG;
                        n_halted = 1'b1;
                    end else begin
                        for (int j = 0; j < MNEMONIC_CHARS; j++) begin
                            if (r_pos == POS_W'(j)) begin
                                n_mnem[8*j +: 8] = w_c;
                            end
                        end
                        n_pos = r_pos + 1'b1;
                    end
                end
                PH_ARG1, PH_ARG2, PH_ARG3: begin
                    if (w_blank) begin
                        n_phase = r_phase;
                    end else if (w_c == CH_COMMA) begin
                        if (r_phase >= 3'(ARG_COUNT)) begin
                            w_kind   = EVT_TOO_MANY;
                            n_halted = 1'b1;
                        end else begin
                            n_phase = r_phase + 3'd1;
                            n_pos   = '0;
                        end
                    end else if (w_eol) begin
                        w_kind  = EVT_FINISH;
                        w_clear = 1'b1;
                    end else if (r_pos >= POS_W'(ARG_CHARS)) begin
                        w_kind   = EVT_TOO_LONG;
                        n_halted = 1'b1;
                    end else begin
                        for (int k = 0; k < ARG_COUNT; k++) begin
                            for (int j = 0; j < ARG_CHARS; j++) begin
                                if (r_phase == 3'(k + 1) && r_pos == POS_W'(j)) begin
                                    n_args[k][8*j +: 8] = w_c;
                                end
                            end
                        end
                        n_pos = r_pos + 1'b1;
                    end
                end
                PH_COMMENT: begin
                    if (w_eol) begin
                        n_phase = PH_MNEM;
                    end
                end
                default: begin
                    n_phase = PH_MNEM;
                end
            endcase
        end
        if (w_clear || (w_take && w_c == CH_NUL)) begin
            n_mnem  = '0;
            n_args  = '0;
            n_pos   = '0;
            n_phase = PH_MNEM;
        end
        if (w_take && w_c == CH_NUL) begin
            n_halted = 1'b0;
        end
    end

    // event carries the texts as they stood when the line ended
    assign o_push         = w_take && (w_kind != EVT_NONE || w_c == CH_NUL);
    assign o_evt.prog_end = (w_c == CH_NUL);
    assign o_evt.kind     = w_kind;
    assign o_evt.mnem     = 64'(r_mnem);
    assign o_evt.arg0     = w_label ? 64'(CH_COLON) : w_lane[0];
    assign o_evt.arg1     = w_label ? 64'd0 : w_lane[1];
    assign o_evt.arg2     = w_label ? 64'd0 : w_lane[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MNEM;
            r_pos    <= '0;
            r_mnem   <= '0;
            r_args   <= '0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_mnem   <= n_mnem;
            r_args   <= n_args;
            r_halted <= n_halted;
        end
    end

endmodule

FILE: design/altv_queue.sv
module altv_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  altv_pkg::t_line_evt i_wdata,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output altv_pkg::t_line_evt o_rdata
);
    import altv_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_line_evt        r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

FILE: design/altv_back.sv
module altv_back #(
    parameter int SLOT_COUNT = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  altv_pkg::t_line_evt i_evt,
    output logic                o_pop,
    altv_result_if.source       o_result
);
    import altv_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT);

    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_drop, n_drop;
    logic              r_valid, n_valid;
    logic [1:0]        r_status, n_status;
    logic [4:0]        r_keyword, n_keyword;
    logic [7:0]        r_slot_out, n_slot_out;
    logic [63:0]       r_mnem, n_mnem;
    logic [63:0]       r_arg0, n_arg0;
    logic [63:0]       r_arg1, n_arg1;
    logic [63:0]       r_arg2, n_arg2;
    t_class            w_class;
    logic [SLOT_W:0]   w_slot_inc;

    assign o_pop      = i_valid && (!r_valid || o_result.ready);
    assign w_class    = f_classify(i_evt.mnem, i_evt.arg0[7:0], i_evt.arg1[7:0]);
    assign w_slot_inc = (SLOT_W+1)'(r_slot) + 1'b1;

    always_comb begin
        n_slot     = r_slot;
        n_drop     = r_drop;
        n_valid    = r_valid && !o_result.ready;
        n_status   = r_status;
        n_keyword  = r_keyword;
        n_slot_out = r_slot_out;
        n_mnem     = r_mnem;
        n_arg0     = r_arg0;
        n_arg1     = r_arg1;
        n_arg2     = r_arg2;
        if (o_pop) begin
            if (!r_drop && i_evt.kind != EVT_NONE) begin
                n_valid    = 1'b1;
                n_slot_out = 8'(r_slot);
                n_mnem     = i_evt.mnem;
                n_arg0     = i_evt.arg0;
                n_arg1     = i_evt.arg1;
                n_arg2     = i_evt.arg2;
                n_keyword  = KW_ON_ERROR;
                case (i_evt.kind)
                    EVT_FINISH: begin
                        if (w_class.ok) begin
                            n_status  = ST_STORED;
                            n_keyword = w_class.kw;
                            if (w_class.kw == KW_LABEL) begin
                                n_arg1 = {i_evt.arg1[63:8], 8'(r_slot)};
                            end
                            n_slot = (w_slot_inc >= (SLOT_W+1)'(SLOT_COUNT)) ? '0
                                     : w_slot_inc[SLOT_W-1:0];
                        end else begin
                            n_status = ST_INVALID;
                            n_drop   = 1'b1;
                        end
                    end
                    EVT_TOO_LONG: begin
                        n_status = ST_TOO_LONG;
                        n_drop   = 1'b1;
                    end
                    EVT_TOO_MANY: begin
                        n_status = ST_TOO_MANY;
                        n_drop   = 1'b1;
                    end
                    default: begin
                        n_status = ST_STORED;
                    end
                endcase
            end
            if (i_evt.prog_end) begin
                n_slot = '0;
                n_drop = 1'b0;
            end
        end
    end

    assign o_result.valid           = r_valid;
    assign o_result.status          = r_status;
    assign o_result.keyword         = r_keyword;
    assign o_result.slot            = r_slot_out;
    assign o_result.mnemonic_text   = r_mnem;
    assign o_result.first_arg_text  = r_arg0;
    assign o_result.second_arg_text = r_arg1;
    assign o_result.third_arg_text  = r_arg2;

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_keyword  <= n_keyword;
        r_slot_out <= n_slot_out;
        r_mnem     <= n_mnem;
        r_arg0     <= n_arg0;
        r_arg1     <= n_arg1;
        r_arg2     <= n_arg2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_drop  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_slot  <= n_slot;
            r_drop  <= n_drop;
            r_valid <= n_valid;
        end
    end

endmodule

FILE: design/asm_line_tokenizer_validator_unit.sv
// assembly line tokenizer and validator
// i_char carries program text, one byte per item; byte 0 ends the program,
// newline or carriage return ends a line. o_result carries one item per
// finished line: status, keyword code, program slot and the four packed texts
// (first char in the low byte, zero padded).
// a byte is taken in every cycle while the line queue has room, so the
// sustained rate is one byte per clock. a line result passes from the line
// queue into the output register, where it is held until it is taken.
// the front parser moves line events into a four-entry queue; the back end
// validates them, numbers slots and fills the output register. while the
// receiver stalls the output register holds its item, the queue fills and
// i_char.ready drops only once four line events are waiting.
// after an error result further lines are dropped until byte 0, which
// restarts slot numbering. reset (synchronous, active low) empties the queue
// and the output register and puts the parser at the start of a line.
module asm_line_tokenizer_validator_unit #(
    parameter int MNEMONIC_CHARS = 8,
    parameter int ARG_CHARS      = 8,
    parameter int ARG_COUNT      = 3,
    parameter int SLOT_COUNT     = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    altv_char_if.sink     i_char,
    altv_result_if.source o_result
);
    import altv_pkg::*;

    // line events between the parser and the validator
    t_line_evt w_push_evt;
    t_line_evt w_head_evt;
    logic      w_push;
    logic      w_full;
    logic      w_head_valid;
    logic      w_pop;

    // front: splits the byte stream into lines and arguments
    altv_front #(
        .MNEMONIC_CHARS (MNEMONIC_CHARS),
        .ARG_CHARS      (ARG_CHARS),
        .ARG_COUNT      (ARG_COUNT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_evt   (w_push_evt)
    );

    // short queue so a stalled receiver does not stop the parser at once
    altv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_evt),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_rdata (w_head_evt)
    );

    // back: keyword check, slot numbering, error drop, output register
    altv_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_head_valid),
        .i_evt    (w_head_evt),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

endmodule
